// ===== src/iir_df1_pkg.sv =====
// Shared types, constants and register codes for the direct form I recursive filter.
`timescale 1ns / 1ps
`default_nettype none

package iir_df1_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 18;
  localparam int unsigned FracBits = 14;
  localparam int unsigned MaxOrder = 3;
  localparam int unsigned DefaultOrder = 3;

  // A product is 34 bits; seven of them summed need three more.
  localparam int unsigned ProdW = SampleW + CoefW;
  localparam int unsigned AccW  = ProdW + $clog2(2 * MaxOrder + 1);

  localparam int unsigned NumRegs = 2 * MaxOrder + 1;
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t RegFf0 = 3'd0;
  localparam cfg_idx_t RegFf1 = 3'd1;
  localparam cfg_idx_t RegFf2 = 3'd2;
  localparam cfg_idx_t RegFf3 = 3'd3;
  localparam cfg_idx_t RegFb1 = 3'd4;
  localparam cfg_idx_t RegFb2 = 3'd5;
  localparam cfg_idx_t RegFb3 = 3'd6;

  // 1.0 in Q3.14, the reset value of the leading feedforward weight.
  localparam coef_t CoefOne = coef_t'(1 << FracBits);

  localparam acc_t RoundHalf = acc_t'(1 << (FracBits - 1));
  localparam acc_t SatMax    = acc_t'(32767);
  localparam acc_t SatMin    = acc_t'(-32768);

  typedef struct packed {
    sample_t sample;
    logic    first_sample;
  } in_item_t;

  typedef struct packed {
    sample_t filtered_sample;
    logic    saturated;
  } out_item_t;

  // Coefficient bank handed from the register file to the datapath.
  // There is no feedback slot 0, the leading feedback weight being 1.0.
  typedef struct packed {
    coef_t [MaxOrder:0] ff;
    coef_t [MaxOrder:1] fb;
  } coef_bank_t;

endpackage

`default_nettype wire

// ===== src/iir_df1_coef_regs.sv =====
// Coefficient register file written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none

module iir_df1_coef_regs (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_en_i,
  input  wire iir_df1_pkg::cfg_idx_t wr_index_i,
  input  wire iir_df1_pkg::coef_t    wr_data_i,
  output iir_df1_pkg::coef_bank_t    coefs_o
);
  import iir_df1_pkg::*;

  // Reset bank: unity leading feedforward weight, every other weight zero.
  localparam coef_bank_t CoefReset = '{ff: {{MaxOrder{coef_t'(0)}}, CoefOne}, fb: '0};

  coef_bank_t coefs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= CoefReset;
    end else if (wr_en_i) begin
      case (wr_index_i)
        RegFf0: coefs_q.ff[0] <= wr_data_i;
        RegFf1: coefs_q.ff[1] <= wr_data_i;
        RegFf2: coefs_q.ff[2] <= wr_data_i;
        RegFf3: coefs_q.ff[3] <= wr_data_i;
        RegFb1: coefs_q.fb[1] <= wr_data_i;
        RegFb2: coefs_q.fb[2] <= wr_data_i;
        RegFb3: coefs_q.fb[3] <= wr_data_i;
        default: ;  // Indexes past the last register are ignored.
      endcase
    end
  end

  assign coefs_o = coefs_q;

endmodule

`default_nettype wire

// ===== src/iir_df1_datapath.sv =====
// Multiply-accumulate, rounding and saturation for one filter output.
`timescale 1ns / 1ps
`default_nettype none

module iir_df1_datapath #(
  parameter int unsigned FilterOrder = iir_df1_pkg::DefaultOrder
) (
  input  wire iir_df1_pkg::sample_t                   sample_i,
  input  wire iir_df1_pkg::sample_t [FilterOrder-1:0] x_hist_i,
  input  wire iir_df1_pkg::sample_t [FilterOrder-1:0] y_hist_i,
  input  wire iir_df1_pkg::coef_bank_t                coefs_i,
  output iir_df1_pkg::out_item_t                      result_o
);
  import iir_df1_pkg::*;

  function automatic prod_t mul(sample_t s, coef_t c);
    mul = prod_t'(s) * prod_t'(c);
  endfunction

  acc_t acc;
  acc_t rounded;
  acc_t scaled;

  always_comb begin
    acc = acc_t'(mul(sample_i, coefs_i.ff[0]));
    for (int unsigned j = 0; j < FilterOrder; j++) begin
      acc = acc + acc_t'(mul(x_hist_i[j], coefs_i.ff[j+1]))
                - acc_t'(mul(y_hist_i[j], coefs_i.fb[j+1]));
    end
    // Round half toward plus infinity, then drop the fraction bits.
    rounded = acc + RoundHalf;
    scaled  = rounded >>> FracBits;

    if (scaled > SatMax) begin
      result_o.filtered_sample = SatMax[SampleW-1:0];
      result_o.saturated       = 1'b1;
    end else if (scaled < SatMin) begin
      result_o.filtered_sample = SatMin[SampleW-1:0];
      result_o.saturated       = 1'b1;
    end else begin
      result_o.filtered_sample = scaled[SampleW-1:0];
      result_o.saturated       = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/iir_direct_form_one.sv =====
// Top level of the direct form I recursive filter with its handshake stages.
// Each accepted sample's result is registered into the output stage.
// Throughput: one sample per cycle unless the output stalls; the feedback loop
// is combinational, through the datapath from input to history registers.
// Reset (rst_ni low, asynchronous) empties both stages, clears the sample
// histories and loads the leading feedforward weight with 1.0, others with 0.
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_one #(
  parameter int unsigned FilterOrder = iir_df1_pkg::DefaultOrder
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire iir_df1_pkg::in_item_t  in_data_i,

  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output iir_df1_pkg::out_item_t      out_data_o,

  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire iir_df1_pkg::cfg_idx_t  cfg_index_i,
  input  wire iir_df1_pkg::coef_t     cfg_data_i
);
  import iir_df1_pkg::*;

  // The input stage holds one accepted sample; the output stage holds its
  // result until the downstream side takes it. Each stage moves forward
  // whenever the stage after it is empty or being emptied, so a sample can
  // enter in every cycle while no result is held, and one more while a result waits.
  logic       s1_valid_q, s1_valid_d;
  in_item_t   s1_data_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q;

  logic       advance;
  logic       in_accept;

  // Histories of past inputs and past (saturated) outputs, newest at index 0.
  sample_t [FilterOrder-1:0] x_hist_q;
  sample_t [FilterOrder-1:0] y_hist_q;
  sample_t [FilterOrder-1:0] x_eff;
  sample_t [FilterOrder-1:0] y_eff;

  coef_bank_t coefs;
  out_item_t  result;

  // Configuration writes are always taken, so the user must write only while idle.
  assign cfg_ready_o = 1'b1;

  iir_df1_coef_regs u_coef_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .coefs_o    (coefs)
  );

  // A sample that opens a new record sees an all-zero past.
  assign x_eff = s1_data_q.first_sample ? '0 : x_hist_q;
  assign y_eff = s1_data_q.first_sample ? '0 : y_hist_q;

  iir_df1_datapath #(
    .FilterOrder (FilterOrder)
  ) u_datapath (
    .sample_i (s1_data_q.sample),
    .x_hist_i (x_eff),
    .y_hist_i (y_eff),
    .coefs_i  (coefs),
    .result_o (result)
  );

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
    if (advance && s1_valid_q) begin
      out_data_q <= result;
    end
  end

  // The histories advance exactly when a sample leaves the input stage, so
  // the next sample, loaded in the same cycle, already sees them updated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_hist_q <= '0;
      y_hist_q <= '0;
    end else if (advance && s1_valid_q) begin
      x_hist_q[0] <= s1_data_q.sample;
      y_hist_q[0] <= result.filtered_sample;
      for (int unsigned i = 1; i < FilterOrder; i++) begin
        x_hist_q[i] <= x_eff[i-1];
        y_hist_q[i] <= y_eff[i-1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/iir_df1_checker.sv =====
// Port-level checker for the recursive filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module iir_df1_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire iir_df1_pkg::out_item_t out_data_o
);
  import iir_df1_pkg::*;

  // Transactions accepted at the input and not yet delivered at the output.
  logic [1:0] pending_q;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (in_take && !out_take) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_take && !in_take) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  // A result is never shown without an input transaction behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 2'd0))
    else $error("result shown with no pending input transaction");

  // At most two transactions are held inside the block.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 2'd2) |-> in_stall_o || out_take)
    else $error("input accepted beyond the block's capacity");

  // With the output stage empty, the input is never held off.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  // The clip flag only comes with a value at a range limit.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      (out_data_o.filtered_sample == SatMax[SampleW-1:0]) ||
      (out_data_o.filtered_sample == SatMin[SampleW-1:0]))
    else $error("saturation flag set on a value inside the range");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

endmodule

bind iir_direct_form_one iir_df1_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== verif/tb_iir_direct_form_one.sv =====
// Self-checking testbench for the direct form I recursive filter top level.
`timescale 1ns / 1ps

module tb_iir_direct_form_one;
  import iir_df1_pkg::*;

  // The block is built at its full order; the predictor uses the same value.
  localparam int unsigned FilterOrder   = DefaultOrder;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PhaseItems    = 125;

  // Index 7 names no register; a write to it must leave every weight alone.
  localparam cfg_idx_t RegUnused = 3'd7;

  localparam coef_t   CoefMax   = coef_t'(131071);
  localparam coef_t   CoefMin   = coef_t'(-131072);
  localparam sample_t SampleMax = sample_t'(32767);
  localparam sample_t SampleMin = sample_t'(-32768);

  // Coefficient styles for one random phase.
  typedef enum int {
    StyleStable,
    StyleFullRange,
    StyleExtreme,
    StyleAllMax,
    StyleAllMin
  } coef_style_e;

  // Every input of the block starts at a known value.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_t  cfg_index_i = '0;
  coef_t     cfg_data_i  = '0;

  // Predictor state: its own copy of the weights and of both histories.
  coef_t   ff_weight [0:MaxOrder];
  coef_t   fb_weight [1:MaxOrder];
  sample_t x_past    [0:MaxOrder-1];
  sample_t y_past    [0:MaxOrder-1];

  // Filter outputs predicted for accepted samples, oldest first.
  out_item_t pending_outputs [$];

  int errors       = 0;
  int samples_in   = 0;
  int results_out  = 0;
  int saturations  = 0;
  int records      = 0;
  int cfg_writes   = 0;
  int idle_cycles  = 0;

  // Receiver control: a per-result random wait and a one-off long hold.
  int stall_hold_left = 0;
  int rx_wait_left    = 0;
  bit rx_idle_en      = 1'b1;
  bit tx_idle_en      = 1'b1;

  iir_direct_form_one #(
    .FilterOrder(FilterOrder)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One step of the filter on the predictor's state. The accumulator is kept
  // exactly in 64 bits; the result is rounded half up from Q.14 and clipped.
  function automatic out_item_t iir_predict(in_item_t item);
    longint    acc;
    longint    y;
    out_item_t r;
    int        j;
    if (item.first_sample) begin
      for (j = 0; j < MaxOrder; j++) begin
        x_past[j] = '0;
        y_past[j] = '0;
      end
    end
    acc = longint'(ff_weight[0]) * longint'(item.sample);
    for (j = 1; j <= FilterOrder; j++) begin
      acc += longint'(ff_weight[j]) * longint'(x_past[j-1]);
      acc -= longint'(fb_weight[j]) * longint'(y_past[j-1]);
    end
    y = (acc + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
    r.saturated = 1'b0;
    if (y > 32767) begin
      y = 32767;
      r.saturated = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      r.saturated = 1'b1;
    end
    r.filtered_sample = sample_t'(y);
    // The clipped value is what the feedback path remembers.
    for (j = MaxOrder - 1; j > 0; j--) begin
      x_past[j] = x_past[j-1];
      y_past[j] = y_past[j-1];
    end
    x_past[0] = item.sample;
    y_past[0] = r.filtered_sample;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Monitor: outputs are checked before the new input is predicted, since a
  // result never leaves in the same cycle as the sample that causes it.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_out++;
        if (out_data_o.saturated === 1'b1) saturations++;
        if (pending_outputs.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    out_data_o.filtered_sample));
        end else begin
          want = pending_outputs.pop_front();
          if (out_data_o.filtered_sample !== want.filtered_sample)
            report_mismatch($sformatf("filtered_sample: expected %0d, got %0d",
                                      want.filtered_sample, out_data_o.filtered_sample));
          if (out_data_o.saturated !== want.saturated)
            report_mismatch($sformatf("saturated: expected %0b, got %0b",
                                      want.saturated, out_data_o.saturated));
        end
        rx_wait_left = rx_idle_en ? $urandom_range(0, 14) : 0;
      end
      if (in_valid_i && !in_stall_o) begin
        samples_in++;
        pending_outputs.push_back(iir_predict(in_data_i));
      end
    end
  end

  // Receiver: stall is driven at the falling edge from the hold and wait counts.
  always @(negedge clk_i) begin
    if (stall_hold_left > 0) begin
      out_stall_i <= 1'b1;
      stall_hold_left--;
    end else if (rx_wait_left > 0) begin
      out_stall_i <= 1'b1;
      rx_wait_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: ends the run when no transaction happens on any channel for
  // too long. The longest legal quiet stretch is the receiver hold.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one sample after a random gap and wait until it is taken. Valid is
  // left high after acceptance; the next send or drain decides its next value.
  task automatic send_sample(sample_t value, logic first);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 14) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: value, first_sample: first};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every predicted output has been checked.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk_i);
  endtask

  // Write one register and mirror the write into the predictor's weights.
  task automatic write_coef(cfg_idx_t idx, coef_t value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegFf0: ff_weight[0] = value;
      RegFf1: ff_weight[1] = value;
      RegFf2: ff_weight[2] = value;
      RegFf3: ff_weight[3] = value;
      RegFb1: fb_weight[1] = value;
      RegFb2: fb_weight[2] = value;
      RegFb3: fb_weight[3] = value;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic coef_t pick_coef(coef_style_e style, int span);
    case (style)
      StyleStable:    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
      StyleFullRange: return coef_t'($urandom);
      StyleAllMax:    return CoefMax;
      StyleAllMin:    return CoefMin;
      default: begin
        case ($urandom_range(0, 3))
          0:       return CoefMax;
          1:       return CoefMin;
          2:       return '0;
          default: return coef_t'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SampleMax;
      1:       return SampleMin;
      2, 3:    return sample_t'(int'($urandom_range(0, 400)) - 200);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // With only the reset weights the block must pass samples through unchanged.
  task automatic test_reset_weights();
    send_sample(SampleMax, 1'b1);
    send_sample(SampleMin, 1'b0);
    send_sample('0, 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(1), 1'b1);
    wait_drained();
  endtask

  // Clipping at both rails with the largest weights of each sign, then the
  // rounding at and beside exact halves with a weight of one least significant bit.
  task automatic test_rounding_and_clipping();
    write_coef(RegFf0, CoefMax);
    send_sample(SampleMax, 1'b1);
    send_sample(SampleMin, 1'b0);
    wait_drained();
    write_coef(RegFf0, CoefMin);
    send_sample(SampleMin, 1'b1);
    send_sample(SampleMax, 1'b0);
    wait_drained();
    write_coef(RegFf0, coef_t'(1));
    send_sample(sample_t'(8192), 1'b1);
    send_sample(sample_t'(-8192), 1'b0);
    send_sample(sample_t'(8191), 1'b0);
    send_sample(sample_t'(-8193), 1'b0);
    wait_drained();
  endtask

  // Impulse responses through all taps, cleared by the first-sample mark both
  // at a record start and in the middle of a ringing response.
  task automatic test_history_and_clear();
    write_coef(RegFf0, coef_t'(16384));
    write_coef(RegFf1, coef_t'(8192));
    write_coef(RegFf2, coef_t'(-4096));
    write_coef(RegFf3, coef_t'(2048));
    write_coef(RegFb1, coef_t'(-8192));
    write_coef(RegFb2, coef_t'(4096));
    write_coef(RegFb3, coef_t'(-2048));
    write_coef(RegUnused, CoefMax);
    send_sample(sample_t'(1000), 1'b1);
    repeat (4) send_sample('0, 1'b0);
    send_sample(sample_t'(1000), 1'b1);
    send_sample('0, 1'b0);
    send_sample(sample_t'(-20000), 1'b0);
    send_sample('0, 1'b1);
    wait_drained();
  endtask

  // Random coefficient sets, each followed by records of random length. Most
  // marks fall on record starts; a few break a record in the middle.
  task automatic test_random_records();
    coef_style_e style;
    int          sent;
    int          rec_len;
    int          p;
    int          i;
    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      if (p == 0) style = StyleAllMax;
      else if (p == 1) style = StyleAllMin;
      else begin
        case ($urandom_range(0, 3))
          0, 1:    style = StyleStable;
          2:       style = StyleFullRange;
          default: style = StyleExtreme;
        endcase
      end
      write_coef(RegFf0, pick_coef(style, 16384));
      write_coef(RegFf1, pick_coef(style, 16384));
      write_coef(RegFf2, pick_coef(style, 16384));
      write_coef(RegFf3, pick_coef(style, 16384));
      write_coef(RegFb1, pick_coef(style, 4096));
      write_coef(RegFb2, pick_coef(style, 4096));
      write_coef(RegFb3, pick_coef(style, 4096));
      if ($urandom_range(0, 2) == 0) write_coef(RegUnused, coef_t'($urandom));
      // Some phases run without gaps on one side or both.
      tx_idle_en = ($urandom_range(0, 2) != 0);
      rx_idle_en = ($urandom_range(0, 2) != 0);
      sent = 0;
      while (sent < PhaseItems) begin
        rec_len = $urandom_range(1, 40);
        records++;
        for (i = 0; i < rec_len && sent < PhaseItems; i++) begin
          send_sample(pick_sample(), (i == 0) || ($urandom_range(0, 19) == 0));
          sent++;
        end
      end
    end
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // the block fills and stalls its input; then the sender pauses until every
  // result is back before it goes on.
  task automatic test_flow_control();
    int i;
    write_coef(RegFf0, coef_t'(12000));
    write_coef(RegFb1, coef_t'(-6000));
    tx_idle_en = 1'b0;
    @(posedge clk_i);
    stall_hold_left = HoldCycles;
    records++;
    for (i = 0; i < 30; i++) send_sample(pick_sample(), i == 0);
    wait_drained();
    tx_idle_en = 1'b1;
    for (i = 0; i < 10; i++) send_sample(pick_sample(), 1'b0);
    wait_drained();
    for (i = 0; i < 10; i++) send_sample(pick_sample(), 1'b0);
    wait_drained();
  endtask

  initial begin
    int k;
    // Predictor state after reset: unity leading weight, everything else zero.
    for (k = 0; k <= MaxOrder; k++) ff_weight[k] = '0;
    for (k = 1; k <= MaxOrder; k++) fb_weight[k] = '0;
    for (k = 0; k < MaxOrder; k++) begin
      x_past[k] = '0;
      y_past[k] = '0;
    end
    ff_weight[0] = CoefOne;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_weights();
    test_rounding_and_clipping();
    test_history_and_clear();
    test_random_records();
    test_flow_control();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_outputs.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_outputs.size()));

    $display("Run covered %0d samples in %0d records, %0d results (%0d clipped).",
             samples_in, records, results_out, saturations);
    $display("Weights were reprogrammed %0d times across %0d random sets and a long hold.",
             cfg_writes, NumPhases);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/iir_df1_pkg.sv
src/iir_df1_coef_regs.sv
src/iir_df1_datapath.sv
src/iir_direct_form_one.sv
src/iir_df1_checker.sv
verif/tb_iir_direct_form_one.sv
